### hw/rtl/fpsa_pkg.sv
// ----------------------------------------------------------------------------
// fpsa_pkg
// Types and codes shared by the segment allocator and its submodules.
// ----------------------------------------------------------------------------
package fpsa_pkg;

    localparam logic       OP_ALLOC = 1'b0;
    localparam logic       OP_FREE  = 1'b1;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [1:0] CFG_FIT_MODE  = 2'd0;
    localparam logic [1:0] CFG_POOL_SIZE = 2'd1;

    localparam logic [15:0] POOL_SIZE_RESET = 16'd4096;

    typedef struct packed {
        logic        opcode;
        logic [15:0] req_size;
        logic [15:0] free_addr;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] addr;
    } t_rsp;

    // Verdict of the gap unit for one table step.
    typedef struct packed {
        logic        fits;
        logic        take;
        logic        match;
        logic [15:0] size;
    } t_gap_res;

endpackage

### hw/rtl/fpsa_ram.sv
// ----------------------------------------------------------------------------
// fpsa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fpsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/fpsa_gap_unit.sv
// ----------------------------------------------------------------------------
// fpsa_gap_unit
// Shared compare unit: sizes one gap, applies the fit policy and checks a
// segment against the offset being freed.
// ----------------------------------------------------------------------------
module fpsa_gap_unit #(
    parameter int HEADER_BYTES = 24
) (
    input  logic [16:0]               i_begin,
    input  logic [15:0]               i_end,
    input  logic [16:0]               i_need,
    input  logic [1:0]                i_mode,
    input  logic                      i_found,
    input  logic [15:0]               i_pick_size,
    input  logic [15:0]               i_seg_start,
    input  logic [15:0]               i_faddr,
    output fpsa_pkg::t_gap_res        o_res
);
    import fpsa_pkg::*;

    localparam logic [16:0] HDR = 17'(HEADER_BYTES);

    logic [16:0] diff;
    logic [15:0] size;
    logic        fits;

    always_comb begin
        diff = {1'b0, i_end} - i_begin;
        // A gap whose end lies before its begin counts as empty.
        size = ({1'b0, i_end} > i_begin) ? diff[15:0] : 16'd0;
        fits = (i_need <= {1'b0, size});
        o_res.size  = size;
        o_res.fits  = fits;
        o_res.take  = fits && (!i_found
                    || (i_mode == FIT_BEST  && size < i_pick_size)
                    || (i_mode == FIT_WORST && size > i_pick_size));
        o_res.match = (({1'b0, i_seg_start} + HDR) == {1'b0, i_faddr});
    end

endmodule

### hw/rtl/fit_policy_segment_allocator_unit.sv
// ----------------------------------------------------------------------------
// fit_policy_segment_allocator_unit
// Segment allocator over a byte pool with first, best or worst fit placement.
// ----------------------------------------------------------------------------
// A command is taken when i_start is high while o_busy is low; exactly one
// item comes back on o_result, marked by o_valid for a single cycle, and the
// receiver cannot stall it, so it must take every item when it appears.
// The segment table lives in one RAM with a registered read, and every scan
// walks it one entry at a time through a shared gap unit, reading an entry in
// S_READ and judging it in S_EVAL. An allocate scans the gaps (the gap before
// each live segment, then the tail gap, stopping early under first fit), then
// opens a hole by moving the entries above the chosen gap up one place and
// writes the new segment into it. A free scans until the matching offset and
// then closes the table up behind it. A full table, an unused fit mode or a
// free on an empty table are answered from S_IDLE without o_busy rising. The
// longest operation is a best or worst fit allocate into the first gap of a
// table one short of full; the result shows in the same cycle that busy drops.
// The configuration port is always ready and must only be written while
// o_busy is low and no item is outstanding. The table needs no clearing pass:
// only entries below the live count are ever used.
// ----------------------------------------------------------------------------
module fit_policy_segment_allocator_unit #(
    parameter int MAX_SEGMENTS = 16,
    parameter int HEADER_BYTES = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  fpsa_pkg::t_cmd    i_cmd,
    output logic              o_busy,
    output logic              o_valid,
    output fpsa_pkg::t_rsp    o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);
    import fpsa_pkg::*;

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);
    localparam logic [CW-1:0] ONE     = CW'(1);
    localparam logic [16:0]   HDR     = 17'(HEADER_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_SHIFT_RD,
        S_SHIFT_WR
    } t_state;

    t_state        r_state;
    logic          r_op;
    logic [16:0]   r_need;
    logic [15:0]   r_faddr;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_count;
    logic [16:0]   r_prev_end;
    logic          r_found;
    logic [CW-1:0] r_pick;
    logic [15:0]   r_pick_size;
    logic [16:0]   r_pick_begin;
    logic [1:0]    r_mode;
    logic [15:0]   r_pool;
    logic          r_valid;
    t_rsp          r_rsp;

    // Table access.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;
    logic [15:0]   rd_start;
    logic [15:0]   rd_len;
    logic [15:0]   gap_end;
    logic          in_table;
    logic [16:0]   pick_addr;
    t_gap_res      gap;

    assign rd_start  = ram_rdata[31:16];
    assign rd_len    = ram_rdata[15:0];
    assign in_table  = (r_idx < r_count);
    // The last gap runs up to the end of the pool.
    assign gap_end   = in_table ? rd_start : r_pool;
    assign pick_addr = r_pick_begin + HDR;

    fpsa_ram #(
        .WIDTH(32),
        .DEPTH(MAX_SEGMENTS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    fpsa_gap_unit #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_gap (
        .i_begin    (r_prev_end),
        .i_end      (gap_end),
        .i_need     (r_need),
        .i_mode     (r_mode),
        .i_found    (r_found),
        .i_pick_size(r_pick_size),
        .i_seg_start(rd_start),
        .i_faddr    (r_faddr),
        .o_res      (gap)
    );

    // RAM port control. In the shift states r_idx is the destination slot.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = r_idx[AW-1:0];
        case (r_state)
            S_SHIFT_RD: begin
                if (r_op == OP_ALLOC) begin
                    ram_raddr = AW'(r_idx - ONE);
                    if (r_idx == r_pick) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_pick[AW-1:0];
                        ram_wdata = {r_pick_begin[15:0], r_need[15:0]};
                    end
                end else begin
                    ram_raddr = AW'(r_idx + ONE);
                end
            end
            S_SHIFT_WR: begin
                ram_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_mode  <= FIT_FIRST;
            r_pool  <= POOL_SIZE_RESET;
        end else begin
            r_valid <= 1'b0;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FIT_MODE:  r_mode <= i_cfg_data[1:0];
                    CFG_POOL_SIZE: r_pool <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_op         <= i_cmd.opcode;
                        r_need       <= {1'b0, i_cmd.req_size} + HDR;
                        r_faddr      <= i_cmd.free_addr;
                        r_idx        <= '0;
                        r_prev_end   <= '0;
                        r_found      <= 1'b0;
                        r_pick_size  <= '0;
                        r_rsp.addr   <= '0;
                        if (i_cmd.opcode == OP_ALLOC) begin
                            if (r_count == MAX_CNT) begin
                                r_rsp.status <= ST_FULL;
                                r_valid      <= 1'b1;
                            end else if (r_mode != FIT_FIRST && r_mode != FIT_BEST
                                         && r_mode != FIT_WORST) begin
                                r_rsp.status <= ST_NOSPACE;
                                r_valid      <= 1'b1;
                            end else begin
                                r_state <= S_READ;
                            end
                        end else if (r_count == '0) begin
                            r_rsp.status <= ST_NOTFOUND;
                            r_valid      <= 1'b1;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end

                S_READ: begin
                    r_state <= S_EVAL;
                end

                S_EVAL: begin
                    if (r_op == OP_ALLOC) begin
                        if (gap.take) begin
                            r_found      <= 1'b1;
                            r_pick       <= r_idx;
                            r_pick_size  <= gap.size;
                            r_pick_begin <= r_prev_end;
                        end
                        if ((gap.take && r_mode == FIT_FIRST) || !in_table) begin
                            if (gap.take || r_found) begin
                                // Open the hole from the top of the table down.
                                r_idx   <= r_count;
                                r_state <= S_SHIFT_RD;
                            end else begin
                                r_rsp.status <= ST_NOSPACE;
                                r_valid      <= 1'b1;
                                r_state      <= S_IDLE;
                            end
                        end else begin
                            r_prev_end <= {1'b0, rd_start} + {1'b0, rd_len};
                            r_idx      <= r_idx + ONE;
                            r_state    <= S_READ;
                        end
                    end else begin
                        if (gap.match) begin
                            r_state <= S_SHIFT_RD;
                        end else if (r_idx + ONE == r_count) begin
                            r_rsp.status <= ST_NOTFOUND;
                            r_valid      <= 1'b1;
                            r_state      <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + ONE;
                            r_state <= S_READ;
                        end
                    end
                end

                S_SHIFT_RD: begin
                    if (r_op == OP_ALLOC) begin
                        if (r_idx == r_pick) begin
                            r_count      <= r_count + ONE;
                            r_rsp.status <= ST_OK;
                            r_rsp.addr   <= pick_addr[15:0];
                            r_valid      <= 1'b1;
                            r_state      <= S_IDLE;
                        end else begin
                            r_state <= S_SHIFT_WR;
                        end
                    end else begin
                        if (r_idx + ONE == r_count) begin
                            r_count      <= r_count - ONE;
                            r_rsp.status <= ST_OK;
                            r_valid      <= 1'b1;
                            r_state      <= S_IDLE;
                        end else begin
                            r_state <= S_SHIFT_WR;
                        end
                    end
                end

                S_SHIFT_WR: begin
                    r_idx   <= (r_op == OP_ALLOC) ? r_idx - ONE : r_idx + ONE;
                    r_state <= S_SHIFT_RD;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_result    = r_rsp;
    assign o_cfg_ready = 1'b1;

endmodule

### hw/rtl/fpsa_checker.sv
// ----------------------------------------------------------------------------
// fpsa_checker
// Port-level checks on the segment allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fpsa_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              o_busy,
    input  logic              o_valid,
    input  fpsa_pkg::t_rsp    o_result
);
    import fpsa_pkg::*;

    // An item is answered only once the block is free again.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result shown while busy");

    // An accepted command either starts work or answers at once.
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_valid))
        else $error("accepted command vanished");

    // Leaving the busy state always delivers the item.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> o_valid)
        else $error("work ended without a result");

    // Failed requests carry no offset.
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != ST_OK) |-> (o_result.addr == 16'd0))
        else $error("error result with non-zero offset");

endmodule

bind fit_policy_segment_allocator_unit fpsa_checker u_fpsa_checker (.*);
